### rtl/ebcs_pkg.sv
package ebcs_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_EXEC  = 2'd2,
    CMD_SETPC = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] address;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [15:0] prog_counter;
    logic [7:0]  accum;
    logic [7:0]  index_x;
    logic [7:0]  index_y;
    logic [7:0]  stack_ptr;
    logic [7:0]  status_flags;
    logic [3:0]  cycles_taken;
    logic        speed_high;
    logic        bad_opcode;
  } res_t;

  typedef enum logic [3:0] {
    K_ALU, K_BIT, K_CPX, K_CPY, K_INC, K_DEC, K_BR, K_JSR, K_BSR, K_IMPL, K_ILL
  } kind_t;

  typedef enum logic [3:0] {
    AM_IMP, AM_IMM, AM_ZP, AM_ZPX, AM_ABS, AM_ABSX, AM_ABSY, AM_IZX, AM_IZY, AM_IZP,
    AM_REL
  } amode_t;

  typedef struct packed {
    kind_t      kind;
    amode_t     am;
    logic [3:0] cyc;
  } dec_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RDW, ST_OP, ST_B1, ST_B2, ST_PL, ST_PH, ST_EXE, ST_EXT, ST_PUSHLO,
    ST_FINISH
  } st_t;

  localparam int FLAG_C = 0;
  localparam int FLAG_Z = 1;
  localparam int FLAG_I = 2;
  localparam int FLAG_D = 3;
  localparam int FLAG_T = 5;
  localparam int FLAG_V = 6;
  localparam int FLAG_N = 7;

  localparam logic [7:0] STACK_PAGE = 8'h01;

  localparam logic [2:0] ALU_ORA = 3'd0;
  localparam logic [2:0] ALU_AND = 3'd1;
  localparam logic [2:0] ALU_EOR = 3'd2;
  localparam logic [2:0] ALU_ADC = 3'd3;
  localparam logic [2:0] ALU_SBC = 3'd7;

  localparam logic [7:0] OP_SXY = 8'h02, OP_SAX = 8'h22, OP_SAY = 8'h42;
  localparam logic [7:0] OP_CLA = 8'h62, OP_CLX = 8'h82, OP_CLY = 8'hC2;
  localparam logic [7:0] OP_BPL = 8'h10, OP_BMI = 8'h30, OP_BVC = 8'h50;
  localparam logic [7:0] OP_BVS = 8'h70, OP_BRA = 8'h80, OP_BCC = 8'h90;
  localparam logic [7:0] OP_BCS = 8'hB0, OP_BNE = 8'hD0, OP_BEQ = 8'hF0;
  localparam logic [7:0] OP_CLC = 8'h18, OP_SEC = 8'h38, OP_CLI = 8'h58;
  localparam logic [7:0] OP_SEI = 8'h78, OP_CLV = 8'hB8, OP_CLD = 8'hD8;
  localparam logic [7:0] OP_SED = 8'hF8, OP_SET = 8'hF4;
  localparam logic [7:0] OP_CSL = 8'h54, OP_CSH = 8'hD4;
  localparam logic [7:0] OP_INA = 8'h1A, OP_INX = 8'hE8, OP_INY = 8'hC8;
  localparam logic [7:0] OP_DEX = 8'hCA, OP_DEY = 8'h88;
  localparam logic [7:0] OP_TAX = 8'hAA, OP_TAY = 8'hA8;
  localparam logic [7:0] OP_BIT_ZP = 8'h24, OP_BIT_ABS = 8'h2C, OP_BIT_IMM = 8'h89;
  localparam logic [7:0] OP_CPX_IMM = 8'hE0, OP_CPX_ZP = 8'hE4, OP_CPX_ABS = 8'hEC;
  localparam logic [7:0] OP_CPY_IMM = 8'hC0, OP_CPY_ZP = 8'hC4, OP_CPY_ABS = 8'hCC;
  localparam logic [7:0] OP_INC_ZP = 8'hE6, OP_INC_ZPX = 8'hF6;
  localparam logic [7:0] OP_INC_ABS = 8'hEE, OP_INC_ABSX = 8'hFE;
  localparam logic [7:0] OP_DEC_ZP = 8'hC6, OP_DEC_ZPX = 8'hD6;
  localparam logic [7:0] OP_DEC_ABS = 8'hCE, OP_DEC_ABSX = 8'hDE;
  localparam logic [7:0] OP_JSR = 8'h20, OP_BSR = 8'h44;
  localparam logic [7:0] OP_ADC_IZP = 8'h72, OP_SBC_IZP = 8'hF2;

  function automatic dec_t decode(input logic [7:0] op);
    dec_t d;
    logic [2:0] grp;
    grp = op[7:5];
    d.kind = K_ILL;
    d.am = AM_IMP;
    d.cyc = 4'd2;
    if ((grp <= ALU_ADC || grp == ALU_SBC) && op[0] && !op[1]) begin
      d.kind = K_ALU;
      case (op[4:2])
        3'd0: begin d.am = AM_IZX; d.cyc = 4'd7; end
        3'd1: begin d.am = AM_ZP; d.cyc = 4'd4; end
        3'd2: begin d.am = AM_IMM; d.cyc = 4'd2; end
        3'd3: begin d.am = AM_ABS; d.cyc = 4'd5; end
        3'd4: begin d.am = AM_IZY; d.cyc = 4'd7; end
        3'd5: begin d.am = AM_ZPX; d.cyc = 4'd4; end
        3'd6: begin d.am = AM_ABSY; d.cyc = 4'd5; end
        default: begin d.am = AM_ABSX; d.cyc = 4'd5; end
      endcase
    end else if (op == OP_ADC_IZP || op == OP_SBC_IZP) begin
      d.kind = K_ALU; d.am = AM_IZP; d.cyc = 4'd7;
    end else begin
      case (op)
        OP_SXY, OP_SAX, OP_SAY, OP_CSL, OP_CSH: begin
          d.kind = K_IMPL; d.cyc = 4'd3;
        end
        OP_CLA, OP_CLX, OP_CLY, OP_CLC, OP_SEC, OP_CLI, OP_SEI, OP_CLV, OP_CLD,
        OP_SED, OP_SET, OP_INA, OP_INX, OP_INY, OP_DEX, OP_DEY, OP_TAX, OP_TAY: begin
          d.kind = K_IMPL; d.cyc = 4'd2;
        end
        OP_BPL, OP_BMI, OP_BVC, OP_BVS, OP_BRA, OP_BCC, OP_BCS, OP_BNE, OP_BEQ: begin
          d.kind = K_BR; d.am = AM_REL;
        end
        OP_JSR: begin d.kind = K_JSR; d.am = AM_ABS; d.cyc = 4'd7; end
        OP_BSR: begin d.kind = K_BSR; d.am = AM_REL; d.cyc = 4'd8; end
        OP_BIT_ZP: begin d.kind = K_BIT; d.am = AM_ZP; d.cyc = 4'd4; end
        OP_BIT_ABS: begin d.kind = K_BIT; d.am = AM_ABS; d.cyc = 4'd5; end
        OP_BIT_IMM: begin d.kind = K_BIT; d.am = AM_IMM; end
        OP_CPX_IMM: begin d.kind = K_CPX; d.am = AM_IMM; end
        OP_CPX_ZP: begin d.kind = K_CPX; d.am = AM_ZP; d.cyc = 4'd4; end
        OP_CPX_ABS: begin d.kind = K_CPX; d.am = AM_ABS; d.cyc = 4'd5; end
        OP_CPY_IMM: begin d.kind = K_CPY; d.am = AM_IMM; end
        OP_CPY_ZP: begin d.kind = K_CPY; d.am = AM_ZP; d.cyc = 4'd4; end
        OP_CPY_ABS: begin d.kind = K_CPY; d.am = AM_ABS; d.cyc = 4'd5; end
        OP_INC_ZP: begin d.kind = K_INC; d.am = AM_ZP; d.cyc = 4'd6; end
        OP_INC_ZPX: begin d.kind = K_INC; d.am = AM_ZPX; d.cyc = 4'd6; end
        OP_INC_ABS: begin d.kind = K_INC; d.am = AM_ABS; d.cyc = 4'd7; end
        OP_INC_ABSX: begin d.kind = K_INC; d.am = AM_ABSX; d.cyc = 4'd7; end
        OP_DEC_ZP: begin d.kind = K_DEC; d.am = AM_ZP; d.cyc = 4'd6; end
        OP_DEC_ZPX: begin d.kind = K_DEC; d.am = AM_ZPX; d.cyc = 4'd6; end
        OP_DEC_ABS: begin d.kind = K_DEC; d.am = AM_ABS; d.cyc = 4'd7; end
        OP_DEC_ABSX: begin d.kind = K_DEC; d.am = AM_ABSX; d.cyc = 4'd7; end
        default: begin d.kind = K_ILL; d.am = AM_IMP; d.cyc = 4'd2; end
      endcase
    end
    return d;
  endfunction

endpackage

### rtl/ebcs_front.sv
module ebcs_front import ebcs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd,
  input  logic [15:0] address,
  input  logic [7:0]  data_byte,
  output logic        item_valid,
  output item_t       item,
  input  logic        item_take
);

  item_t      slots [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       do_push;

  assign full       = (count == 2'd2);
  assign item_valid = (count != 2'd0);
  assign item       = slots[rd_ptr];
  assign do_push    = push && !full;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= '{cmd: cmd_t'(cmd), address: address, data_byte: data_byte};
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (item_take) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, item_take};
    end
  end

endmodule

### rtl/ebcs_exec.sv
module ebcs_exec import ebcs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  input  item_t item,
  output logic  item_take,
  output logic  res_valid,
  output res_t  res,
  input  logic  pop
);

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] p;
  } alu_out_t;

  logic [7:0] mem [65536];
  logic [15:0] mem_addr;
  logic        mem_we;
  logic [7:0]  mem_wd;
  logic [7:0]  rdata;

  st_t         state, state_next;
  logic [15:0] pc, pc_next;
  logic [7:0]  a, a_next, x, x_next, y, y_next, sp, sp_next, p, p_next;
  logic        spd, spd_next;
  logic [7:0]  op, op_next;
  dec_t        dec, dec_next;
  logic        t, t_next;
  logic [7:0]  lo, lo_next, zptr, zptr_next, val, val_next, rbyte, rbyte_next;
  logic [15:0] ea, ea_next;
  logic [3:0]  cyc, cyc_next;
  logic        ill, ill_next;
  logic        res_valid_next;
  res_t        res_next;

  function automatic logic [7:0] with_nz(input logic [7:0] pf, input logic [7:0] v);
    logic [7:0] q;
    q = pf;
    q[FLAG_N] = v[7];
    q[FLAG_Z] = (v == 8'd0);
    return q;
  endfunction

  function automatic alu_out_t alu(input logic [2:0] grp, input logic [7:0] d,
                                   input logic [7:0] v, input logic [7:0] pf);
    alu_out_t o;
    logic [7:0] vv;
    logic [8:0] sum;
    o.p = pf;
    vv = (grp == ALU_SBC) ? ~v : v;
    sum = {1'b0, d} + {1'b0, vv} + {8'd0, pf[FLAG_C]};
    case (grp)
      ALU_ORA: o.r = d | v;
      ALU_AND: o.r = d & v;
      ALU_EOR: o.r = d ^ v;
      default: begin
        o.r = sum[7:0];
        o.p[FLAG_C] = sum[8];
        o.p[FLAG_V] = !(d[7] ^ vv[7]) && (d[7] ^ sum[7]);
      end
    endcase
    o.p = with_nz(o.p, o.r);
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    rdata <= mem[mem_addr];
  end

  always_comb begin
    logic [7:0]  b;
    logic [7:0]  z;
    logic [7:0]  pt;
    logic [15:0] base;
    logic [15:0] eaddr;
    logic [15:0] ret;
    logic [7:0]  diff;
    logic [7:0]  cmpr;
    logic [7:0]  nv;
    logic        cond;
    alu_out_t    ao;
    dec_t        d;

    state_next = state;
    pc_next = pc; a_next = a; x_next = x; y_next = y; sp_next = sp; p_next = p;
    spd_next = spd; op_next = op; dec_next = dec; t_next = t; lo_next = lo;
    zptr_next = zptr; val_next = val; rbyte_next = rbyte; ea_next = ea;
    cyc_next = cyc; ill_next = ill;
    res_valid_next = res_valid && !pop;
    res_next = res;
    item_take = 1'b0;
    mem_addr = pc;
    mem_we = 1'b0;
    mem_wd = 8'd0;
    b = rdata;
    z = 8'd0;
    pt = p;
    pt[FLAG_T] = 1'b0;
    base = {rdata, lo};
    eaddr = 16'd0;
    ret = pc - 16'd1;
    cmpr = (dec.kind == K_CPX) ? x : y;
    diff = cmpr - rdata;
    nv = (dec.kind == K_INC) ? rdata + 8'd1 : rdata - 8'd1;
    cond = 1'b0;
    ao = alu(op[7:5], a, rdata, p);
    d = decode(rdata);

    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          item_take = 1'b1;
          rbyte_next = 8'd0;
          cyc_next = 4'd0;
          ill_next = 1'b0;
          case (item.cmd)
            CMD_LOAD: begin
              mem_addr = item.address;
              mem_we = 1'b1;
              mem_wd = item.data_byte;
              state_next = ST_FINISH;
            end
            CMD_READ: begin
              mem_addr = item.address;
              state_next = ST_RDW;
            end
            CMD_SETPC: begin
              pc_next = item.address;
              state_next = ST_FINISH;
            end
            default: begin
              pc_next = pc + 16'd1;
              state_next = ST_OP;
            end
          endcase
        end
      end
      ST_RDW: begin
        rbyte_next = rdata;
        state_next = ST_FINISH;
      end
      ST_OP: begin
        op_next = rdata;
        dec_next = d;
        t_next = p[FLAG_T];
        p_next = pt;
        cyc_next = d.cyc;
        case (d.am)
          AM_IMP: begin
            state_next = ST_FINISH;
            if (d.kind == K_ILL) begin
              pc_next = pc + 16'd1;
              ill_next = 1'b1;
            end else begin
              case (rdata)
                OP_SXY: begin x_next = y; y_next = x; end
                OP_SAX: begin a_next = x; x_next = a; end
                OP_SAY: begin a_next = y; y_next = a; end
                OP_CLA: a_next = 8'd0;
                OP_CLX: x_next = 8'd0;
                OP_CLY: y_next = 8'd0;
                OP_CLC: p_next[FLAG_C] = 1'b0;
                OP_SEC: p_next[FLAG_C] = 1'b1;
                OP_CLI: p_next[FLAG_I] = 1'b0;
                OP_SEI: p_next[FLAG_I] = 1'b1;
                OP_CLV: p_next[FLAG_V] = 1'b0;
                OP_CLD: p_next[FLAG_D] = 1'b0;
                OP_SED: p_next[FLAG_D] = 1'b1;
                OP_SET: p_next[FLAG_T] = 1'b1;
                OP_CSL: spd_next = 1'b0;
                OP_CSH: spd_next = 1'b1;
                OP_INA: begin a_next = a + 8'd1; p_next = with_nz(pt, a + 8'd1); end
                OP_INX: begin x_next = x + 8'd1; p_next = with_nz(pt, x + 8'd1); end
                OP_INY: begin y_next = y + 8'd1; p_next = with_nz(pt, y + 8'd1); end
                OP_DEX: begin x_next = x - 8'd1; p_next = with_nz(pt, x - 8'd1); end
                OP_DEY: begin y_next = y - 8'd1; p_next = with_nz(pt, y - 8'd1); end
                OP_TAX: begin x_next = a; p_next = with_nz(pt, a); end
                OP_TAY: begin y_next = a; p_next = with_nz(pt, a); end
                default: ;
              endcase
            end
          end
          AM_IMM: begin
            pc_next = pc + 16'd1;
            state_next = ST_EXE;
          end
          default: begin
            pc_next = pc + 16'd1;
            state_next = ST_B1;
          end
        endcase
      end
      ST_B1: begin
        lo_next = b;
        case (dec.am)
          AM_ZP, AM_ZPX: begin
            z = (dec.am == AM_ZPX) ? b + x : b;
            ea_next = {8'd0, z};
            mem_addr = {8'd0, z};
            state_next = ST_EXE;
          end
          AM_IZX, AM_IZY, AM_IZP: begin
            z = (dec.am == AM_IZX) ? b + x : b;
            zptr_next = z;
            mem_addr = {8'd0, z};
            state_next = ST_PL;
          end
          AM_REL: begin
            if (dec.kind == K_BSR) begin
              ea_next = pc + {{8{b[7]}}, b};
              mem_addr = {STACK_PAGE, sp};
              mem_we = 1'b1;
              mem_wd = ret[15:8];
              sp_next = sp - 8'd1;
              state_next = ST_PUSHLO;
            end else begin
              case (op)
                OP_BPL: cond = !p[FLAG_N];
                OP_BMI: cond = p[FLAG_N];
                OP_BVC: cond = !p[FLAG_V];
                OP_BVS: cond = p[FLAG_V];
                OP_BCC: cond = !p[FLAG_C];
                OP_BCS: cond = p[FLAG_C];
                OP_BNE: cond = !p[FLAG_Z];
                OP_BEQ: cond = p[FLAG_Z];
                default: cond = 1'b1;
              endcase
              if (cond) begin
                pc_next = pc + {{8{b[7]}}, b};
                cyc_next = 4'd4;
              end else begin
                cyc_next = 4'd2;
              end
              state_next = ST_FINISH;
            end
          end
          default: begin
            pc_next = pc + 16'd1;
            state_next = ST_B2;
          end
        endcase
      end
      ST_B2: begin
        if (dec.kind == K_JSR) begin
          ea_next = base;
          mem_addr = {STACK_PAGE, sp};
          mem_we = 1'b1;
          mem_wd = ret[15:8];
          sp_next = sp - 8'd1;
          state_next = ST_PUSHLO;
        end else begin
          case (dec.am)
            AM_ABSX: eaddr = base + {8'd0, x};
            AM_ABSY: eaddr = base + {8'd0, y};
            default: eaddr = base;
          endcase
          ea_next = eaddr;
          mem_addr = eaddr;
          state_next = ST_EXE;
        end
      end
      ST_PL: begin
        lo_next = rdata;
        mem_addr = {8'd0, zptr + 8'd1};
        state_next = ST_PH;
      end
      ST_PH: begin
        eaddr = (dec.am == AM_IZY) ? base + {8'd0, y} : base;
        if (eaddr[15:8] != base[15:8]) cyc_next = cyc + 4'd1;
        ea_next = eaddr;
        mem_addr = eaddr;
        state_next = ST_EXE;
      end
      ST_EXE: begin
        state_next = ST_FINISH;
        case (dec.kind)
          K_ALU: begin
            if (t) begin
              val_next = rdata;
              mem_addr = {8'd0, x};
              state_next = ST_EXT;
            end else begin
              a_next = ao.r;
              p_next = ao.p;
            end
          end
          K_BIT: begin
            p_next[FLAG_N] = rdata[7];
            p_next[FLAG_V] = rdata[6];
            p_next[FLAG_Z] = ((rdata & a) == 8'd0);
          end
          K_CPX, K_CPY: begin
            p_next = with_nz(p, diff);
            p_next[FLAG_C] = (cmpr >= rdata);
          end
          default: begin
            mem_addr = ea;
            mem_we = 1'b1;
            mem_wd = nv;
            p_next = with_nz(p, nv);
          end
        endcase
      end
      ST_EXT: begin
        ao = alu(op[7:5], rdata, val, p);
        mem_addr = {8'd0, x};
        mem_we = 1'b1;
        mem_wd = ao.r;
        p_next = ao.p;
        state_next = ST_FINISH;
      end
      ST_PUSHLO: begin
        mem_addr = {STACK_PAGE, sp};
        mem_we = 1'b1;
        mem_wd = ret[7:0];
        sp_next = sp - 8'd1;
        pc_next = ea;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!res_valid || pop) begin
          res_valid_next = 1'b1;
          res_next = '{read_data: rbyte, prog_counter: pc, accum: a, index_x: x,
                       index_y: y, stack_ptr: sp, status_flags: p, cycles_taken: cyc,
                       speed_high: spd, bad_opcode: ill};
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    op <= op_next; dec <= dec_next; t <= t_next; lo <= lo_next; zptr <= zptr_next;
    val <= val_next; rbyte <= rbyte_next; ea <= ea_next; cyc <= cyc_next;
    ill <= ill_next; res <= res_next;
    if (rst) begin
      state <= ST_IDLE;
      pc <= 16'd0; a <= 8'd0; x <= 8'd0; y <= 8'd0; sp <= 8'd0; p <= 8'd0;
      spd <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      pc <= pc_next; a <= a_next; x <= x_next; y <= y_next; sp <= sp_next;
      p <= p_next; spd <= spd_next;
      res_valid <= res_valid_next;
    end
  end

endmodule

### rtl/eight_bit_cpu_step_unit.sv
// Each beat loads or reads one byte of the 64 KiB memory, sets the program counter, or
// runs one instruction, and gives one result beat carrying the registers afterwards.
// Loads, program counter writes and reads end in a result state. An instruction makes
// one access per state to the single-port memory (opcode, operands, pointer bytes,
// data, write-back or stack pushes) before its result state. A two-beat input queue
// lets new beats in while an instruction runs or a result waits.
module eight_bit_cpu_step_unit import ebcs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd,
  input  logic [15:0] address,
  input  logic [7:0]  data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  read_data,
  output logic [15:0] prog_counter,
  output logic [7:0]  accum,
  output logic [7:0]  index_x,
  output logic [7:0]  index_y,
  output logic [7:0]  stack_ptr,
  output logic [7:0]  status_flags,
  output logic [3:0]  cycles_taken,
  output logic        speed_high,
  output logic        bad_opcode
);

  logic  item_valid;
  item_t item;
  logic  item_take;
  logic  res_valid;
  res_t  res;

  ebcs_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .cmd(cmd), .address(address),
    .data_byte(data_byte), .item_valid(item_valid), .item(item), .item_take(item_take)
  );

  ebcs_exec u_exec (
    .clk(clk), .rst(rst), .item_valid(item_valid), .item(item), .item_take(item_take),
    .res_valid(res_valid), .res(res), .pop(pop)
  );

  assign empty        = !res_valid;
  assign read_data    = res.read_data;
  assign prog_counter = res.prog_counter;
  assign accum        = res.accum;
  assign index_x      = res.index_x;
  assign index_y      = res.index_y;
  assign stack_ptr    = res.stack_ptr;
  assign status_flags = res.status_flags;
  assign cycles_taken = res.cycles_taken;
  assign speed_high   = res.speed_high;
  assign bad_opcode   = res.bad_opcode;

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench import ebcs_pkg::*; ();

  typedef struct {
    item_t it;
    res_t  r;
    bit    drain;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  cmd = '0;
  logic [15:0] address = '0;
  logic [7:0]  data_byte = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  read_data;
  logic [15:0] prog_counter;
  logic [7:0]  accum;
  logic [7:0]  index_x;
  logic [7:0]  index_y;
  logic [7:0]  stack_ptr;
  logic [7:0]  status_flags;
  logic [3:0]  cycles_taken;
  logic        speed_high;
  logic        bad_opcode;

  eight_bit_cpu_step_unit i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the core used to work out each result.
  logic [7:0]  mem [0:65535];
  bit          mem_known [0:65535];
  logic [15:0] pc;
  logic [7:0]  acc, xr, yr, sp, flags;
  logic        speed;
  res_t        before_insn;
  bit          drain_next;

  beat_t pending_beats[$];
  res_t  awaited_results[$];
  int    total_beats, beats_sent, results_seen, insns_planned, errors;
  int    stall_left;

  function automatic res_t snapshot(logic [7:0] rdata, logic [3:0] cyc, logic ill);
    res_t r;
    r = '{rdata, pc, acc, xr, yr, sp, flags, cyc, speed, ill};
    return r;
  endfunction

  function automatic void add_beat(cmd_t c, logic [15:0] a, logic [7:0] d, res_t r);
    beat_t b;
    b.it = '{c, a, d};
    b.r = r;
    b.drain = drain_next;
    drain_next = 0;
    pending_beats.push_back(b);
  endfunction

  // A byte never written is loaded with random content before it is read.
  function automatic logic [7:0] rd(logic [15:0] a);
    logic [7:0] d;
    if (!mem_known[a]) begin
      d = 8'($urandom);
      mem[a] = d;
      mem_known[a] = 1;
      add_beat(CMD_LOAD, a, d, before_insn);
    end
    return mem[a];
  endfunction

  function automatic void wr(logic [15:0] a, logic [7:0] v);
    mem[a] = v;
    mem_known[a] = 1;
  endfunction

  function automatic logic [7:0] fetch();
    logic [7:0] v;
    v = rd(pc);
    pc = pc + 16'd1;
    return v;
  endfunction

  function automatic logic [15:0] fetch_abs();
    logic [7:0] lo, hi;
    lo = fetch();
    hi = fetch();
    return {hi, lo};
  endfunction

  function automatic logic [15:0] zp_pointer(logic [7:0] z);
    logic [7:0] lo, hi;
    lo = rd({8'h00, z});
    hi = rd({8'h00, z + 8'd1});
    return {hi, lo};
  endfunction

  function automatic void set_nz(logic [7:0] v);
    flags[FLAG_Z] = (v == 8'h00);
    flags[FLAG_N] = v[7];
  endfunction

  function automatic logic [15:0] operand_addr(logic [4:0] mode, output logic [3:0] cyc);
    logic [15:0] a, b;
    logic [7:0] z;
    case (mode)
      5'h01: begin cyc = 7; z = fetch() + xr; a = zp_pointer(z); end
      5'h05: begin cyc = 4; a = {8'h00, fetch()}; end
      5'h09: begin cyc = 2; a = pc; pc = pc + 16'd1; end
      5'h0D: begin cyc = 5; a = fetch_abs(); end
      5'h11: begin
        cyc = 7;
        b = zp_pointer(fetch());
        a = b + {8'h00, yr};
        if (a[15:8] != b[15:8]) cyc = 8;
      end
      5'h12: begin cyc = 7; a = zp_pointer(fetch()); end
      5'h15: begin cyc = 4; z = fetch() + xr; a = {8'h00, z}; end
      5'h19: begin cyc = 5; a = fetch_abs() + {8'h00, yr}; end
      default: begin cyc = 5; a = fetch_abs() + {8'h00, xr}; end
    endcase
    return a;
  endfunction

  function automatic void alu(logic [2:0] op, logic [7:0] v, bit t);
    logic [7:0] d, r;
    logic [8:0] sum;
    d = t ? rd({8'h00, xr}) : acc;
    case (op)
      ALU_ORA: r = d | v;
      ALU_AND: r = d & v;
      ALU_EOR: r = d ^ v;
      default: begin
        if (op == ALU_SBC) v = ~v;
        sum = {1'b0, d} + {1'b0, v} + {8'h00, flags[FLAG_C]};
        r = sum[7:0];
        flags[FLAG_C] = sum[8];
        flags[FLAG_V] = (d[7] == v[7]) && (d[7] != r[7]);
      end
    endcase
    set_nz(r);
    if (t) wr({8'h00, xr}, r);
    else acc = r;
  endfunction

  function automatic void compare(logic [7:0] reg_v, logic [7:0] v);
    set_nz(reg_v - v);
    flags[FLAG_C] = (reg_v >= v);
  endfunction

  function automatic void bit_test(logic [7:0] v);
    flags[FLAG_Z] = ((v & acc) == 8'h00);
    flags[FLAG_N] = v[7];
    flags[FLAG_V] = v[6];
  endfunction

  function automatic void step_mem(logic [15:0] a, bit up);
    logic [7:0] v;
    v = up ? rd(a) + 8'd1 : rd(a) - 8'd1;
    set_nz(v);
    wr(a, v);
  endfunction

  function automatic logic [3:0] branch(bit cond);
    logic [7:0] off;
    off = fetch();
    if (!cond) return 4'd2;
    pc = pc + {{8{off[7]}}, off};
    return 4'd4;
  endfunction

  function automatic void push_word(logic [15:0] v);
    wr({STACK_PAGE, sp}, v[15:8]);
    sp = sp - 8'd1;
    wr({STACK_PAGE, sp}, v[7:0]);
    sp = sp - 8'd1;
  endfunction

  function automatic void run_insn(output logic [3:0] cyc, output logic ill);
    logic [7:0] op, tmp;
    logic [2:0] grp;
    logic [15:0] a;
    bit t;
    op = fetch();
    grp = op[7:5];
    t = flags[FLAG_T];
    flags[FLAG_T] = 0;
    ill = 0;
    cyc = 2;
    if ((grp <= ALU_ADC || grp == ALU_SBC) && op[0] && !op[1]) begin
      a = operand_addr(op[4:0], cyc);
      alu(grp, rd(a), t);
    end else if (op == OP_ADC_IZP || op == OP_SBC_IZP) begin
      a = operand_addr(5'h12, cyc);
      alu(grp, rd(a), t);
    end else begin
      case (op)
        OP_SXY: begin tmp = yr; yr = xr; xr = tmp; cyc = 3; end
        OP_SAX: begin tmp = acc; acc = xr; xr = tmp; cyc = 3; end
        OP_SAY: begin tmp = acc; acc = yr; yr = tmp; cyc = 3; end
        OP_CLA: acc = 0;
        OP_CLX: xr = 0;
        OP_CLY: yr = 0;
        OP_BPL: cyc = branch(!flags[FLAG_N]);
        OP_BMI: cyc = branch(flags[FLAG_N]);
        OP_BVC: cyc = branch(!flags[FLAG_V]);
        OP_BVS: cyc = branch(flags[FLAG_V]);
        OP_BRA: cyc = branch(1);
        OP_BCC: cyc = branch(!flags[FLAG_C]);
        OP_BCS: cyc = branch(flags[FLAG_C]);
        OP_BNE: cyc = branch(!flags[FLAG_Z]);
        OP_BEQ: cyc = branch(flags[FLAG_Z]);
        OP_CLC: flags[FLAG_C] = 0;
        OP_SEC: flags[FLAG_C] = 1;
        OP_CLI: flags[FLAG_I] = 0;
        OP_SEI: flags[FLAG_I] = 1;
        OP_CLV: flags[FLAG_V] = 0;
        OP_CLD: flags[FLAG_D] = 0;
        OP_SED: flags[FLAG_D] = 1;
        OP_SET: flags[FLAG_T] = 1;
        OP_CSL: begin speed = 0; cyc = 3; end
        OP_CSH: begin speed = 1; cyc = 3; end
        OP_INA: begin acc = acc + 8'd1; set_nz(acc); end
        OP_INX: begin xr = xr + 8'd1; set_nz(xr); end
        OP_INY: begin yr = yr + 8'd1; set_nz(yr); end
        OP_DEX: begin xr = xr - 8'd1; set_nz(xr); end
        OP_DEY: begin yr = yr - 8'd1; set_nz(yr); end
        OP_TAX: begin xr = acc; set_nz(xr); end
        OP_TAY: begin yr = acc; set_nz(yr); end
        OP_BIT_ZP: begin bit_test(rd({8'h00, fetch()})); cyc = 4; end
        OP_BIT_ABS: begin bit_test(rd(fetch_abs())); cyc = 5; end
        OP_BIT_IMM: bit_test(fetch());
        OP_CPX_IMM: compare(xr, fetch());
        OP_CPX_ZP: begin compare(xr, rd({8'h00, fetch()})); cyc = 4; end
        OP_CPX_ABS: begin compare(xr, rd(fetch_abs())); cyc = 5; end
        OP_CPY_IMM: compare(yr, fetch());
        OP_CPY_ZP: begin compare(yr, rd({8'h00, fetch()})); cyc = 4; end
        OP_CPY_ABS: begin compare(yr, rd(fetch_abs())); cyc = 5; end
        OP_INC_ZP: begin step_mem({8'h00, fetch()}, 1); cyc = 6; end
        OP_INC_ZPX: begin tmp = fetch() + xr; step_mem({8'h00, tmp}, 1); cyc = 6; end
        OP_INC_ABS: begin step_mem(fetch_abs(), 1); cyc = 7; end
        OP_INC_ABSX: begin step_mem(fetch_abs() + {8'h00, xr}, 1); cyc = 7; end
        OP_DEC_ZP: begin step_mem({8'h00, fetch()}, 0); cyc = 6; end
        OP_DEC_ZPX: begin tmp = fetch() + xr; step_mem({8'h00, tmp}, 0); cyc = 6; end
        OP_DEC_ABS: begin step_mem(fetch_abs(), 0); cyc = 7; end
        OP_DEC_ABSX: begin step_mem(fetch_abs() + {8'h00, xr}, 0); cyc = 7; end
        OP_JSR: begin
          a = fetch_abs();
          push_word(pc - 16'd1);
          pc = a;
          cyc = 7;
        end
        OP_BSR: begin
          tmp = fetch();
          push_word(pc - 16'd1);
          pc = pc + {{8{tmp[7]}}, tmp};
          cyc = 8;
        end
        default: begin pc = pc + 16'd1; ill = 1; end
      endcase
    end
  endfunction

  function automatic void plan_load(logic [15:0] a, logic [7:0] d);
    wr(a, d);
    add_beat(CMD_LOAD, a, d, snapshot(0, 0, 0));
  endfunction

  function automatic void plan_read(logic [15:0] a);
    logic [7:0] v;
    before_insn = snapshot(0, 0, 0);
    v = rd(a);
    add_beat(CMD_READ, a, 8'($urandom), snapshot(v, 0, 0));
  endfunction

  function automatic void plan_setpc(logic [15:0] a);
    pc = a;
    add_beat(CMD_SETPC, a, 8'($urandom), snapshot(0, 0, 0));
  endfunction

  function automatic void plan_exec();
    logic [3:0] cyc;
    logic ill;
    before_insn = snapshot(0, 0, 0);
    run_insn(cyc, ill);
    insns_planned++;
    add_beat(CMD_EXEC, 16'($urandom), 8'($urandom), snapshot(0, cyc, ill));
  endfunction

  // Places an opcode and two operand bytes at the program counter, then runs it.
  function automatic void plan_insn(logic [7:0] op, logic [7:0] b1, logic [7:0] b2);
    plan_load(pc, op);
    plan_load(pc + 16'd1, b1);
    plan_load(pc + 16'd2, b2);
    plan_exec();
  endfunction

  logic [7:0] other_ops [] = '{
    OP_SXY, OP_SAX, OP_SAY, OP_CLA, OP_CLX, OP_CLY, OP_BPL, OP_BMI, OP_BVC, OP_BVS,
    OP_BRA, OP_BCC, OP_BCS, OP_BNE, OP_BEQ, OP_CLC, OP_SEC, OP_CLI, OP_SEI, OP_CLV,
    OP_CLD, OP_SED, OP_SET, OP_CSL, OP_CSH, OP_INA, OP_INX, OP_INY, OP_DEX, OP_DEY,
    OP_TAX, OP_TAY, OP_BIT_ZP, OP_BIT_ABS, OP_BIT_IMM, OP_CPX_IMM, OP_CPX_ZP, OP_CPX_ABS,
    OP_CPY_IMM, OP_CPY_ZP, OP_CPY_ABS, OP_INC_ZP, OP_INC_ZPX, OP_INC_ABS, OP_INC_ABSX,
    OP_DEC_ZP, OP_DEC_ZPX, OP_DEC_ABS, OP_DEC_ABSX, OP_JSR, OP_BSR, OP_ADC_IZP, OP_SBC_IZP
  };

  function automatic logic [7:0] pick_opcode();
    logic [2:0] grp;
    int r;
    r = $urandom_range(99);
    if (r < 5) return 8'($urandom);
    if (r < 50) begin
      grp = 3'($urandom_range(4));
      if (grp == 3'd4) grp = ALU_SBC;
      return {grp, 3'($urandom_range(7)), 2'b01};
    end
    return other_ops[$urandom_range(other_ops.size() - 1)];
  endfunction

  function automatic void plan_all();
    int r;
    pc = 0; acc = 0; xr = 0; yr = 0; sp = 0; flags = 0; speed = 0;
    drain_next = 0;
    plan_load(16'hFFFF, 8'hFF);
    plan_load(16'h0000, 8'h00);
    plan_read(16'hFFFF);
    plan_read(16'h0000);
    plan_setpc(16'hFFFE);
    plan_insn({ALU_ADC, 3'd2, 2'b01}, 8'h7F, 8'h00);
    plan_insn({ALU_ADC, 3'd2, 2'b01}, 8'h01, 8'h00);
    plan_insn(OP_TAX, 0, 0);
    plan_insn(OP_SET, 0, 0);
    plan_insn({ALU_EOR, 3'd5, 2'b01}, 8'hFF, 0);
    plan_insn(OP_SEC, 0, 0);
    plan_insn({ALU_SBC, 3'd2, 2'b01}, 8'h80, 0);
    plan_insn(OP_TAY, 0, 0);
    plan_insn({ALU_ORA, 3'd4, 2'b01}, 8'hFF, 0);
    plan_insn(OP_CSH, 0, 0);
    plan_insn(8'h03, 0, 0);
    plan_insn(OP_JSR, 8'hFE, 8'hFF);
    plan_insn(OP_BSR, 8'h80, 0);
    plan_insn(OP_BRA, 8'h7F, 0);
    plan_insn(OP_CSL, 0, 0);
    plan_setpc(16'h1000);
    while (pending_beats.size() < 1250) begin
      if (pending_beats.size() > 700 && pending_beats.size() < 720) drain_next = 1;
      r = $urandom_range(99);
      if (r < 5) plan_setpc($urandom_range(3) == 0 ? 16'hFFFD + 16'($urandom_range(2))
                                                    : 16'($urandom));
      else if (r < 10) plan_load(16'($urandom), 8'($urandom));
      else if (r < 15) plan_read(16'($urandom));
      else if (r < 22) begin
        plan_insn(OP_SET, 8'($urandom), 8'($urandom));
        plan_insn(pick_opcode(), 8'($urandom), 8'($urandom));
      end else if (r < 26) plan_exec();
      else plan_insn(pick_opcode(), 8'($urandom), 8'($urandom));
    end
  endfunction

  task automatic report(string field, int got, int want);
    errors++;
    if (errors <= 20)
      $display("mismatch on %s at result %0d: got %0h, expected %0h",
               field, results_seen, got, want);
  endtask

  function automatic int phase();
    return beats_sent * 3 / (total_beats + 1);
  endfunction

  always @(posedge clk) begin
    beat_t b;
    bit offer;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        b = pending_beats.pop_front();
        awaited_results.push_back(b.r);
        beats_sent++;
      end
      offer = pending_beats.size() != 0;
      if (offer && pending_beats[0].drain && awaited_results.size() != 0) offer = 0;
      if (phase() == 0 && $urandom_range(99) < 7) offer = 0;
      if (phase() == 1 && $urandom_range(99) < 55) offer = 0;
      push <= offer;
      if (pending_beats.size() != 0) begin
        cmd <= pending_beats[0].it.cmd;
        address <= pending_beats[0].it.address;
        data_byte <= pending_beats[0].it.data_byte;
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (awaited_results.size() == 0) begin
          report("unexpected beat", 0, 0);
        end else begin
          want = awaited_results.pop_front();
          if (read_data !== want.read_data) report("read_data", read_data, want.read_data);
          if (prog_counter !== want.prog_counter)
            report("prog_counter", prog_counter, want.prog_counter);
          if (accum !== want.accum) report("accum", accum, want.accum);
          if (index_x !== want.index_x) report("index_x", index_x, want.index_x);
          if (index_y !== want.index_y) report("index_y", index_y, want.index_y);
          if (stack_ptr !== want.stack_ptr) report("stack_ptr", stack_ptr, want.stack_ptr);
          if (status_flags !== want.status_flags)
            report("status_flags", status_flags, want.status_flags);
          if (cycles_taken !== want.cycles_taken)
            report("cycles_taken", cycles_taken, want.cycles_taken);
          if (speed_high !== want.speed_high)
            report("speed_high", speed_high, want.speed_high);
          if (bad_opcode !== want.bad_opcode)
            report("bad_opcode", bad_opcode, want.bad_opcode);
        end
        results_seen++;
        if (results_seen == 300) stall_left = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (phase() == 0) begin
        pop <= $urandom_range(99) >= 55;
      end else if (phase() == 1) begin
        pop <= $urandom_range(99) >= 7;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    plan_all();
    total_beats = pending_beats.size();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    while (pending_beats.size() != 0 || awaited_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("Drove %0d beats, %0d of them instructions, and checked %0d results.",
             beats_sent, insns_planned, results_seen);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("PASS eight_bit_cpu_step_unit");
    end else begin
      $display("FAIL eight_bit_cpu_step_unit");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timed out with %0d beats still to send.", pending_beats.size());
    $display("FAIL eight_bit_cpu_step_unit");
    $finish;
  end

endmodule
